// ----- hw/rtl/iva_pkg.sv -----
// Shared types, codes and helpers of the interrupt vector allocator.
package iva_pkg;

  localparam int unsigned VecW    = 8;
  localparam int unsigned GsiW    = 8;
  localparam int unsigned StampW  = 16;
  localparam int unsigned CpuW    = 2;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumOvr  = 4;
  localparam int unsigned EntryW  = 64;

  localparam int unsigned OvrValidBit = 16;
  localparam logic [3:0]  EntryCpuMask = 4'hF;
  localparam logic [2:0]  DelivFixed   = 3'b000;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_LOOKUP     = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVR_A = 3'd0,
    CFG_OVR_B = 3'd1,
    CFG_OVR_C = 3'd2,
    CFG_OVR_D = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              used;
    logic [GsiW-1:0]   gsi;
    logic [StampW-1:0] stamp;
  } slot_t;

  typedef struct packed {
    status_e           status;
    logic [VecW-1:0]   vector_out;
    logic [GsiW-1:0]   gsi_out;
    logic [EntryW-1:0] redirect_entry;
    logic              write_entry;
  } result_t;

  function automatic logic [EntryW-1:0] make_entry(logic [VecW-1:0] vec,
                                                   logic [CpuW-1:0] cpu,
                                                   logic masked);
    logic [EntryW-1:0] w;
    w          = '0;
    w[7:0]     = vec;
    w[10:8]    = DelivFixed;
    w[16]      = masked;
    w[59:56]   = {2'b00, cpu} & EntryCpuMask;
    return w;
  endfunction

endpackage

// ----- hw/rtl/iva_if.sv -----
// Request and result channel interfaces of the interrupt vector allocator.
interface iva_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] cpu;
  logic [7:0] source_number;
  logic       is_irq;
  logic [7:0] query_vector;

  modport source (output valid, action, cpu, source_number, is_irq, query_vector,
                  input ready);
  modport sink   (input valid, action, cpu, source_number, is_irq, query_vector,
                  output ready);
endinterface

interface iva_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  vector_out;
  logic [7:0]  gsi_out;
  logic [63:0] redirect_entry;
  logic        write_entry;

  modport source (output valid, status, vector_out, gsi_out, redirect_entry, write_entry,
                  input ready);
  modport sink   (input valid, status, vector_out, gsi_out, redirect_entry, write_entry,
                  output ready);
endinterface

// ----- hw/rtl/iva_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module iva_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/interrupt_vector_allocator.sv -----
// Interrupt vector allocator: per-cpu vector bitmap with gsi and stamp per slot.
// Register and unregister scan slots FIRST_FREE_VECTOR..NUM_VECTORS-1 through
// one RAM read port, one slot a cycle; lookup reads one slot.
// One word at a time. After reset a clearing pass over all NUM_CPUS*NUM_VECTORS
// slots (1024 by default) initializes the slot RAM before the first word.
module interrupt_vector_allocator
  import iva_pkg::*;
#(
  parameter int unsigned NUM_CPUS          = 4,
  parameter int unsigned NUM_VECTORS       = 256,
  parameter int unsigned FIRST_FREE_VECTOR = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  iva_in_if.sink             in_if,
  iva_out_if.source          out_if
);

  localparam int unsigned Depth = NUM_CPUS * NUM_VECTORS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SlotW = $bits(slot_t);
  localparam logic [VecW-1:0] FirstVec = VecW'(FIRST_FREE_VECTOR);
  localparam logic [VecW-1:0] LastVec  = VecW'(NUM_VECTORS - 1);
  localparam logic [AW-1:0]   LastAddr = AW'(Depth - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0] ovr_q [NumOvr];

  action_e           act_q, act_d;
  logic [CpuW-1:0]   cpu_q, cpu_d;
  logic [GsiW-1:0]   gsi_q, gsi_d;
  logic [AW-1:0]     base_q, base_d;
  logic [VecW-1:0]   idx_q, idx_d;
  logic [VecW-1:0]   hi_q, hi_d;
  logic              issue_q, issue_d;
  logic              chk_q, chk_d;
  logic [VecW-1:0]   chk_idx_q, chk_idx_d;
  logic              found_q, found_d;
  logic [VecW-1:0]   best_q, best_d;
  logic [StampW-1:0] best_age_q, best_age_d;
  logic [GsiW-1:0]   look_gsi_q, look_gsi_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [VecW-1:0]   clr_v_q, clr_v_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             ram_wdata;
  logic [AW-1:0]     ram_raddr;
  slot_t             ram_rdata;
  logic [SlotW-1:0]  ram_rdata_raw;

  logic [GsiW-1:0]   in_gsi;
  logic              in_cpu_ok;
  logic [StampW-1:0] age;

  always_comb begin
    in_gsi = in_if.source_number;
    if (in_if.is_irq) begin
      for (int k = NumOvr - 1; k >= 0; k--) begin
        if (ovr_q[k][OvrValidBit] && ovr_q[k][15:8] == in_if.source_number) begin
          in_gsi = ovr_q[k][7:0];
        end
      end
    end
  end

  assign in_cpu_ok = 32'(in_if.cpu) < NUM_CPUS;
  assign ram_rdata = slot_t'(ram_rdata_raw);
  assign age       = stamp_q - ram_rdata.stamp;
  assign ram_raddr = base_q + AW'(idx_q);
  assign in_if.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cpu_d       = cpu_q;
    gsi_d       = gsi_q;
    base_d      = base_q;
    idx_d       = idx_q;
    hi_d        = hi_q;
    issue_d     = issue_q;
    chk_d       = 1'b0;
    chk_idx_d   = idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_age_d  = best_age_q;
    look_gsi_d  = look_gsi_q;
    stamp_d     = stamp_q;
    clr_addr_d  = clr_addr_q;
    clr_v_d     = clr_v_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = '0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we         = 1'b1;
        ram_wdata.used = (clr_v_q < FirstVec);
        clr_addr_d     = clr_addr_q + 1'b1;
        clr_v_d        = (clr_v_q == LastVec) ? '0 : clr_v_q + 1'b1;
        if (clr_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          act_d   = action_e'(in_if.action);
          cpu_d   = in_if.cpu;
          gsi_d   = in_gsi;
          base_d  = AW'(32'(in_if.cpu) * NUM_VECTORS);
          found_d = 1'b0;
          issue_d = 1'b1;
          idx_d   = FirstVec;
          hi_d    = LastVec;
          state_d = ST_SCAN;
          if (!in_cpu_ok) begin
            act_d   = ACT_NONE;
            state_d = ST_WRITE;
          end else begin
            unique case (action_e'(in_if.action))
              ACT_REGISTER, ACT_UNREGISTER: ;
              ACT_LOOKUP: begin
                idx_d = in_if.query_vector;
                hi_d  = in_if.query_vector;
                if (32'(in_if.query_vector) < FIRST_FREE_VECTOR ||
                    32'(in_if.query_vector) >= NUM_VECTORS) begin
                  state_d = ST_WRITE;
                end
              end
              default: state_d = ST_WRITE;
            endcase
          end
        end
      end
      ST_SCAN: begin
        chk_d = issue_q;
        if (issue_q) begin
          if (idx_q == hi_q) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (chk_q) begin
          unique case (act_q)
            ACT_REGISTER: begin
              if (!ram_rdata.used && !found_q) begin
                found_d = 1'b1;
                best_d  = chk_idx_q;
              end
            end
            ACT_UNREGISTER: begin
              if (ram_rdata.used && ram_rdata.gsi == gsi_q &&
                  (!found_q || age < best_age_q)) begin
                found_d    = 1'b1;
                best_d     = chk_idx_q;
                best_age_d = age;
              end
            end
            ACT_LOOKUP: begin
              if (ram_rdata.used) begin
                found_d    = 1'b1;
                best_d     = chk_idx_q;
                look_gsi_d = ram_rdata.gsi;
              end
            end
            default: ;
          endcase
        end
        if (!issue_q && !chk_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        res_d         = '0;
        res_d.status  = STATUS_NOT_FOUND;
        ram_waddr     = base_q + AW'(best_q);
        ram_wdata.gsi = gsi_q;
        ram_wdata.stamp = stamp_q;
        unique case (act_q)
          ACT_REGISTER: begin
            res_d.gsi_out = gsi_q;
            res_d.status  = STATUS_NO_FREE;
            if (found_q) begin
              ram_we               = 1'b1;
              ram_wdata.used       = 1'b1;
              stamp_d              = stamp_q + 1'b1;
              res_d.status         = STATUS_OK;
              res_d.vector_out     = best_q;
              res_d.redirect_entry = make_entry(best_q, cpu_q, 1'b0);
              res_d.write_entry    = 1'b1;
            end
          end
          ACT_UNREGISTER: begin
            res_d.gsi_out = gsi_q;
            if (found_q) begin
              ram_we               = 1'b1;
              ram_wdata.used       = 1'b0;
              res_d.status         = STATUS_OK;
              res_d.vector_out     = best_q;
              res_d.redirect_entry = make_entry(best_q, cpu_q, 1'b1);
              res_d.write_entry    = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            if (found_q) begin
              res_d.status     = STATUS_OK;
              res_d.vector_out = best_q;
              res_d.gsi_out    = look_gsi_q;
            end
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      stamp_q     <= '0;
      clr_addr_q  <= '0;
      clr_v_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumOvr; k++) begin
        ovr_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      stamp_q     <= stamp_d;
      clr_addr_q  <= clr_addr_d;
      clr_v_q     <= clr_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OVR_A: ovr_q[0] <= cfg_data_i;
          CFG_OVR_B: ovr_q[1] <= cfg_data_i;
          CFG_OVR_C: ovr_q[2] <= cfg_data_i;
          CFG_OVR_D: ovr_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    cpu_q      <= cpu_d;
    gsi_q      <= gsi_d;
    base_q     <= base_d;
    idx_q      <= idx_d;
    hi_q       <= hi_d;
    chk_idx_q  <= chk_idx_d;
    found_q    <= found_d;
    best_q     <= best_d;
    best_age_q <= best_age_d;
    look_gsi_q <= look_gsi_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  iva_ram #(
    .WIDTH (SlotW),
    .DEPTH (Depth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (SlotW'(ram_wdata)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign out_if.valid          = out_valid_q;
  assign out_if.status         = out_q.status;
  assign out_if.vector_out     = out_q.vector_out;
  assign out_if.gsi_out        = out_q.gsi_out;
  assign out_if.redirect_entry = out_q.redirect_entry;
  assign out_if.write_entry    = out_q.write_entry;

endmodule
